// ----- design/grb_pkg.sv -----
// Package for the GPIO register block: beat types, word codes and pin constants.
`default_nettype none

package grb_pkg;

  localparam int unsigned NumPins     = 32;
  localparam int unsigned FselWords   = 4;
  localparam int unsigned PinsPerWord = 10;
  localparam int unsigned FselBits    = 3 * PinsPerWord;

  localparam logic [31:0] PinMask = 32'((64'(1) << NumPins) - 64'(1));

  localparam logic [5:0] WordSet    = 6'd7;
  localparam logic [5:0] WordClr    = 6'd10;
  localparam logic [5:0] WordLev    = 6'd13;
  localparam logic [5:0] WordPud    = 6'd37;
  localparam logic [5:0] WordPudClk = 6'd38;

  localparam logic [2:0] FselOutput = 3'h1;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } grb_op_e;

  typedef struct packed {
    grb_op_e     op;
    logic [5:0]  word_index;
    logic [31:0] write_data;
    logic [31:0] pins_in;
  } grb_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] drive_enable;
    logic [31:0] drive_value;
    logic [63:0] pull_states;
  } grb_rsp_t;

  // Select bits of implemented pins within one select word.
  function automatic logic [FselBits-1:0] fsel_mask(input logic [1:0] w);
    logic [FselBits-1:0] m;
    m = '0;
    for (int k = 0; k < PinsPerWord; k++) begin
      if ((int'(w) * PinsPerWord + k) < NumPins) begin
        m[k*3 +: 3] = 3'h7;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/grb_regs.sv -----
// Register state of the GPIO block: access decode, update and result word.
`default_nettype none

module grb_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire grb_pkg::grb_req_t req_i,
  input  wire logic              upd_i,
  output grb_pkg::grb_rsp_t      rsp_o
);
  import grb_pkg::*;

  logic [FselBits-1:0] fsel_q [FselWords];
  logic [FselBits-1:0] fsel_d [FselWords];
  logic [31:0]         latch_q, latch_d;
  logic [1:0]          pud_q, pud_d;
  logic [1:0]          pull_q [NumPins];
  logic [1:0]          pull_d [NumPins];
  logic                wr;
  logic [31:0]         en;

  assign wr = (req_i.op == OpWrite);

  always_comb begin
    fsel_d  = fsel_q;
    latch_d = latch_q;
    pud_d   = pud_q;
    pull_d  = pull_q;
    if (wr) begin
      if (req_i.word_index < 6'(FselWords)) begin
        fsel_d[req_i.word_index[1:0]] = req_i.write_data[FselBits-1:0] &
                                        fsel_mask(req_i.word_index[1:0]);
      end else if (req_i.word_index == WordSet) begin
        latch_d = (latch_q | req_i.write_data) & PinMask;
      end else if (req_i.word_index == WordClr) begin
        latch_d = latch_q & ~req_i.write_data & PinMask;
      end else if (req_i.word_index == WordPud) begin
        pud_d = req_i.write_data[1:0];
      end else if (req_i.word_index == WordPudClk) begin
        for (int i = 0; i < NumPins; i++) begin
          if (req_i.write_data[i]) begin
            pull_d[i] = pud_q;
          end
        end
      end
    end
  end

  always_comb begin
    en = '0;
    for (int i = 0; i < NumPins; i++) begin
      en[i] = (fsel_d[i / PinsPerWord][(i % PinsPerWord)*3 +: 3] == FselOutput);
    end
  end

  always_comb begin
    rsp_o.read_data = '0;
    if (!wr) begin
      if (req_i.word_index < 6'(FselWords)) begin
        rsp_o.read_data = 32'(fsel_d[req_i.word_index[1:0]]);
      end else if (req_i.word_index == WordLev) begin
        rsp_o.read_data = ((latch_d & en) | (req_i.pins_in & ~en)) & PinMask;
      end else if (req_i.word_index == WordPud) begin
        rsp_o.read_data = 32'(pud_d);
      end
    end
    rsp_o.drive_enable = en;
    rsp_o.drive_value  = latch_d;
    rsp_o.pull_states  = '0;
    for (int i = 0; i < NumPins; i++) begin
      rsp_o.pull_states[2*i +: 2] = pull_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < FselWords; w++) fsel_q[w] <= '0;
      latch_q <= '0;
      pud_q   <= '0;
      for (int i = 0; i < NumPins; i++) pull_q[i] <= '0;
    end else if (upd_i) begin
      fsel_q  <= fsel_d;
      latch_q <= latch_d;
      pud_q   <= pud_d;
      pull_q  <= pull_d;
    end
  end

  a_set_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && wr && req_i.word_index == WordSet |=>
    (latch_q & $past(req_i.write_data & PinMask)) == $past(req_i.write_data & PinMask))
    else $error("set write did not raise latch bits");

  a_clr_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && wr && req_i.word_index == WordClr |=>
    (latch_q & $past(req_i.write_data)) == 32'h0)
    else $error("clear write left latch bits set");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(latch_q) && $stable(pud_q))
    else $error("state changed without an update");

endmodule

`default_nettype wire

// ----- design/gpio_register_block_top.sv -----
// Top level of the GPIO register block: input stage, register state, result stage.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    in_data_i  (grb_req_t)
//   out      out  out_valid_o / out_ready_i  out_data_o (grb_rsp_t)
//
// One beat per cycle while out_ready_i is high; input register, then result register.
// The state update and decode sit between the two registers and are combinational.
// Reset clears the valid flags and register state; pins read input mode, latch zero, no pull.
// A stalled result holds the input stage; in_ready_o follows out_ready_i within the cycle.
`default_nettype none

module gpio_register_block_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire grb_pkg::grb_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output grb_pkg::grb_rsp_t      out_data_o
);
  import grb_pkg::*;

  logic     s1_valid_q;
  grb_req_t s1_data_q;
  logic     out_valid_q;
  grb_rsp_t out_data_q;
  grb_rsp_t rsp;
  logic     adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  grb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (s1_data_q),
    .upd_i  (adv),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (adv) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- test/gpio_register_block_top_test.sv -----
// Testbench for gpio_register_block_top: register-state scoreboard, directed and random accesses.
`default_nettype none

module gpio_register_block_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grb_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  class gpio_shadow;
    logic [29:0] fsel [4];
    logic [31:0] latch;
    logic [1:0]  pull_mode;
    logic [1:0]  pin_pull [32];
    grb_rsp_t    pending [$];
    int unsigned errors;

    function new();
      foreach (fsel[i]) fsel[i] = '0;
      foreach (pin_pull[i]) pin_pull[i] = '0;
      latch = '0;
      pull_mode = '0;
      errors = 0;
    endfunction

    function logic [29:0] implemented_fsel(int unsigned w);
      logic [29:0] m;
      m = '0;
      for (int k = 0; k < 10; k++) begin
        if (w * 10 + k < 32) m[k*3 +: 3] = 3'h7;
      end
      return m;
    endfunction

    function logic [31:0] output_pins();
      logic [31:0] en;
      en = '0;
      for (int p = 0; p < 32; p++) begin
        en[p] = (fsel[p / 10][(p % 10) * 3 +: 3] == 3'h1);
      end
      return en;
    endfunction

    function void note_access(grb_req_t req);
      grb_rsp_t    exp_rsp;
      logic [31:0] en;
      int unsigned w;
      w = int'(req.word_index);
      if (req.op == OpWrite) begin
        if (w < 4) begin
          fsel[w] = req.write_data[29:0] & implemented_fsel(w);
        end else if (req.word_index == WordSet) begin
          latch = latch | req.write_data;
        end else if (req.word_index == WordClr) begin
          latch = latch & ~req.write_data;
        end else if (req.word_index == WordPud) begin
          pull_mode = req.write_data[1:0];
        end else if (req.word_index == WordPudClk) begin
          for (int p = 0; p < 32; p++) begin
            if (req.write_data[p]) pin_pull[p] = pull_mode;
          end
        end
      end
      en = output_pins();
      exp_rsp = '0;
      if (req.op == OpRead) begin
        if (w < 4) exp_rsp.read_data = {2'b00, fsel[w]};
        else if (req.word_index == WordLev) exp_rsp.read_data = (latch & en) | (req.pins_in & ~en);
        else if (req.word_index == WordPud) exp_rsp.read_data = {30'd0, pull_mode};
      end
      exp_rsp.drive_enable = en;
      exp_rsp.drive_value  = latch;
      for (int p = 0; p < 32; p++) exp_rsp.pull_states[2*p +: 2] = pin_pull[p];
      pending.push_back(exp_rsp);
    endfunction

    function void check_result(grb_rsp_t got);
      grb_rsp_t exp_rsp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      exp_rsp = pending.pop_front();
      if (got.read_data !== exp_rsp.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, exp_rsp.read_data, got.read_data);
        errors++;
      end
      if (got.drive_enable !== exp_rsp.drive_enable) begin
        $display("%0t: drive_enable expected %h actual %h", $time,
                 exp_rsp.drive_enable, got.drive_enable);
        errors++;
      end
      if (got.drive_value !== exp_rsp.drive_value) begin
        $display("%0t: drive_value expected %h actual %h", $time,
                 exp_rsp.drive_value, got.drive_value);
        errors++;
      end
      if (got.pull_states !== exp_rsp.pull_states) begin
        $display("%0t: pull_states expected %h actual %h", $time,
                 exp_rsp.pull_states, got.pull_states);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  grb_req_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  grb_rsp_t out_data_o;

  gpio_shadow  shadow;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          rx_hold_req;
  int unsigned cycle_count;

  gpio_register_block_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted beats, then pick next ready
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) shadow.check_result(out_data_o);
      if (rx_hold_req) begin
        hold_left = 60;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_access(input grb_op_e op, input logic [5:0] w,
                             input logic [31:0] data, input logic [31:0] pins);
    grb_req_t req;
    req.op = op;
    req.word_index = w;
    req.write_data = data;
    req.pins_in = pins;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_access(req);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
  endtask

  // select data biased toward output mode so enables get exercised
  function automatic logic [31:0] select_pattern();
    logic [31:0] d;
    d = $urandom;
    for (int k = 0; k < 10; k++) begin
      case ($urandom_range(0, 3))
        0: d[k*3 +: 3] = FselOutput;
        1: d[k*3 +: 3] = 3'h0;
        default: d[k*3 +: 3] = 3'($urandom_range(0, 7));
      endcase
    end
    return d;
  endfunction

  task automatic send_random();
    logic [5:0]  w;
    logic [31:0] data;
    grb_op_e     op;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5: w = 6'($urandom_range(0, FselWords - 1));
      6, 7:   w = WordSet;
      8, 9:   w = WordClr;
      10, 11: w = WordLev;
      12, 13: w = WordPud;
      14, 15: w = WordPudClk;
      default: w = 6'($urandom_range(0, 63));
    endcase
    op = $urandom_range(0, 1) ? OpWrite : OpRead;
    case ($urandom_range(0, 7))
      0: data = '0;
      1: data = '1;
      2, 3: data = select_pattern();
      default: data = $urandom;
    endcase
    send_access(op, w, data, $urandom);
  endtask

  task automatic random_phase(input int unsigned n, input int unsigned idle_pct,
                              input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    shadow         = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold_req    = 1'b0;
    cycle_count    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_access(OpRead, 6'd0, '0, '0);
    send_access(OpRead, WordLev, '0, 32'hA5A5_5A5A);
    for (int w = 0; w < FselWords; w++) send_access(OpWrite, 6'(w), '1, '0);
    for (int w = 0; w < FselWords; w++) send_access(OpRead, 6'(w), '0, '1);
    for (int w = 0; w < FselWords; w++) send_access(OpWrite, 6'(w), 32'h0924_9249, '0);
    send_access(OpWrite, WordSet, '1, '0);
    send_access(OpRead, WordLev, '0, '0);
    send_access(OpWrite, WordClr, 32'h0000_FFFF, '0);
    send_access(OpRead, WordLev, '0, '1);
    send_access(OpWrite, WordPud, '1, '0);
    send_access(OpRead, WordPud, '0, '0);
    send_access(OpWrite, WordPudClk, '1, '0);
    send_access(OpWrite, WordPud, 32'd2, '0);
    send_access(OpWrite, WordPudClk, '0, '0);
    send_access(OpWrite, WordPudClk, 32'hAAAA_AAAA, '0);
    send_access(OpRead, WordSet, '0, '1);
    send_access(OpRead, WordClr, '0, '1);
    send_access(OpRead, WordPudClk, '0, '1);
    send_access(OpWrite, WordLev, '1, '1);
    send_access(OpRead, 6'd63, '0, '1);
    send_access(OpWrite, 6'd63, '1, '1);
    drain();

    random_phase(450, 0, 0);

    // long receiver hold-off while the sender keeps pushing
    rx_hold_req = 1'b1;
    random_phase(30, 0, 0);

    random_phase(450, 68, 0);
    random_phase(450, 0, 68);
    random_phase(450, 9, 9);
    random_phase(100, 0, 0);

    repeat (10) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/grb_pkg.sv
design/grb_regs.sv
design/gpio_register_block_top.sv
test/gpio_register_block_top_test.sv
